// ===== rtl/pfc_pkg.sv =====
// Pixel format converter package: layout codes, register indexes, the
// pixel record passed from front to back, and layout size functions.
// No dependencies.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int BYTE_W    = 8;
  localparam int FMT_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 3;   // holds an output byte count of 0 to 4

  // Layout codes
  localparam logic [FMT_W-1:0] FMT_RGB   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGBA  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_GRAYA = 3'd3;
  localparam logic [FMT_W-1:0] FMT_ALPHA = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT = 2'd1;

  localparam logic [FMT_W-1:0]  FMT_RESET = FMT_RGBA;
  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hff;

  // floor(s / 3) for s <= 765 as (s * 683) >> 11
  localparam int SUM_W      = 10;
  localparam int PROD_W     = 20;
  localparam int GRAY_SHIFT = 11;
  localparam logic [PROD_W-1:0] GRAY_RECIP = 20'd683;

  // One converted pixel, bytes in output order
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] vals;
    logic [CNT_W-1:0]       count;
    logic                   image_end;
  } pix_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Bytes in one pixel of a layout; zero for an unknown layout
  function automatic logic [CNT_W-1:0] layout_bytes(input logic [FMT_W-1:0] f);
    logic [CNT_W-1:0] n;
    case (f)
      FMT_RGB:   n = 3'd3;
      FMT_RGBA:  n = 3'd4;
      FMT_GRAY:  n = 3'd1;
      FMT_GRAYA: n = 3'd2;
      FMT_ALPHA: n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/pixel_format_converter_top.sv =====
// Top level of the pixel format converter: front, pixel queue and back.
// Depends on pfc_pkg, pfc_front, pfc_queue and pfc_back.
`timescale 1ns / 1ps

// Converts a byte stream of pixels between rgb, rgba, gray, gray alpha and
// alpha layouts (codes 0 to 4), selected by register 0 (source) and register
// 1 (target), both resetting to rgba. Any write to either register drops a
// partially gathered pixel. The input side takes one byte per cycle while
// the pixel queue (QUEUE_DEPTH records) has room; when a source pixel
// completes, its converted record enters the queue at the same clock edge
// that accepts the closing byte. The output side gives one byte per cycle
// while out_stall is low and the queue holds a record; a pixel gives as
// many bytes as its target layout has: one to four, four for alpha to rgba.
// The closing byte's record is registered in the queue, then in the output
// register. Bytes of an unknown source layout, pixels cut short by image_end
// and pixels for an unknown target layout give no output.
module pixel_format_converter_top import pfc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_image_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_pixel_last,
  output logic                 out_image_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FMT_W-1:0]     cfg_data
);

  logic      accept;
  logic      push;
  logic      pop;
  pix_rec_t  push_rec;
  pix_rec_t  head;
  q_status_t q_stat;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  pfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_image_end (in_image_end),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_rec     (push_rec)
  );

  pfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  pfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_stat.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_pixel_last (out_pixel_last),
    .out_image_last (out_image_last)
  );

  // Front only pushes when the queue has room
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("pixel record pushed into a full queue");

  // Queue status flags are exclusive
  a_status_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Image end only ever closes a pixel
  a_image_last_on_pixel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_last |-> out_pixel_last)
    else $error("image_last without pixel_last");

  // Back never pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/pfc_front.sv =====
// Front of the pixel format converter: format registers, byte gathering,
// pixel expansion and formatting into a pixel record.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_front import pfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_image_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FMT_W-1:0]     cfg_data,
  output logic                 push,
  output pix_rec_t             push_rec
);

  logic [FMT_W-1:0]  src_fmt_r, src_fmt_nxt;
  logic [FMT_W-1:0]  dst_fmt_r, dst_fmt_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [BYTE_W-1:0] held_red_r, held_green_r, held_blue_r;

  logic [CNT_W-1:0]  need;
  logic              partial;
  logic              complete;
  logic [BYTE_W-1:0] r, g, bl, a, gray;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign need     = layout_bytes(src_fmt_r);
  assign partial  = ({1'b0, pos_r} + 3'd1) < need;
  assign complete = accept && (need != '0) && !partial;

  // Configuration registers and byte position
  always_comb begin
    src_fmt_nxt = src_fmt_r;
    dst_fmt_nxt = dst_fmt_r;
    pos_nxt     = pos_r;
    if (accept) begin
      if (need == '0 || !partial || in_image_end) begin
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
    if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_FORMAT: begin
          src_fmt_nxt = cfg_data;
          pos_nxt     = 2'd0;
        end
        CFG_TARGET_FORMAT: begin
          dst_fmt_nxt = cfg_data;
          pos_nxt     = 2'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_RESET;
      dst_fmt_r <= FMT_RESET;
      pos_r     <= 2'd0;
    end else begin
      src_fmt_r <= src_fmt_nxt;
      dst_fmt_r <= dst_fmt_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // Hold the early bytes of a pixel
  always_ff @(posedge clk) begin
    if (accept && need != '0 && partial && !in_image_end) begin
      case (pos_r)
        2'd0:    held_red_r   <= in_byte;
        2'd1:    held_green_r <= in_byte;
        default: held_blue_r  <= in_byte;
      endcase
    end
  end

  // Expand to red, green, blue, alpha
  always_comb begin
    case (src_fmt_r)
      FMT_RGB: begin
        r = held_red_r; g = held_green_r; bl = in_byte; a = FULL_BYTE;
      end
      FMT_RGBA: begin
        r = held_red_r; g = held_green_r; bl = held_blue_r; a = in_byte;
      end
      FMT_GRAY: begin
        r = in_byte; g = in_byte; bl = in_byte; a = FULL_BYTE;
      end
      FMT_GRAYA: begin
        r = held_red_r; g = held_red_r; bl = held_red_r; a = in_byte;
      end
      default: begin
        r = FULL_BYTE; g = FULL_BYTE; bl = FULL_BYTE; a = in_byte;
      end
    endcase
  end

  // Gray by reciprocal multiply
  assign sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(bl);
  assign prod = PROD_W'(sum) * GRAY_RECIP;
  assign gray = prod[GRAY_SHIFT +: BYTE_W];

  // Format into output byte order
  always_comb begin
    push_rec.vals      = '0;
    push_rec.image_end = in_image_end;
    case (dst_fmt_r)
      FMT_RGB: begin
        push_rec.vals[0] = r; push_rec.vals[1] = g; push_rec.vals[2] = bl;
      end
      FMT_RGBA: begin
        push_rec.vals[0] = r; push_rec.vals[1] = g; push_rec.vals[2] = bl;
        push_rec.vals[3] = a;
      end
      FMT_GRAY:  push_rec.vals[0] = gray;
      FMT_GRAYA: begin
        push_rec.vals[0] = gray; push_rec.vals[1] = a;
      end
      FMT_ALPHA: push_rec.vals[0] = a;
      default: ;
    endcase
    push_rec.count = layout_bytes(dst_fmt_r);
  end

  // Unknown target layouts give nothing
  assign push = complete && (push_rec.count != '0);

endmodule

// ===== rtl/pfc_queue.sv =====
// Small register queue of pixel records between front and back.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_queue import pfc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pix_rec_t  push_rec,
  input  logic      pop,
  output pix_rec_t  head,
  output q_status_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  pix_rec_t            mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == CNT_QW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== rtl/pfc_back.sv =====
// Back of the pixel format converter: serializes each pixel record into
// output bytes through an output register.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_back import pfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pix_rec_t          head,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_pixel_last,
  output logic              out_image_last
);

  logic [1:0]        idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              pix_last_r, img_last_r;
  logic              advance;
  logic              last;

  assign advance = !q_empty && (!valid_r || !out_stall);
  assign last    = ({1'b0, idx_r} + 3'd1) == head.count;
  assign pop     = advance && last;

  // Byte index within the current record and output valid
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (advance) begin
      idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r     <= head.vals[idx_r];
      pix_last_r <= last;
      img_last_r <= last && head.image_end;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_pixel_last = pix_last_r;
  assign out_image_last = img_last_r;

endmodule
